@@ hw/rtl/csr_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN segment reassembler package
// Shared constants and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package csr_pkg;

    // Byte lanes in one emitted word and in one row of the message store.
    localparam int LANES     = 8;
    // Largest number of words emitted for one message, and its counter width.
    localparam int MAX_WORDS = 32;
    localparam int WORDS_W   = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the incoming frame
        logic check;    // filter, store the frame, update count and header
        logic issue;    // read the next word of the message
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;        // the frame under check completes a message to send
        logic last_issue;  // the word being read now is the final one
    } status_t;

endpackage

@@ hw/rtl/csr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module csr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/csr_ctrl.sv @@
// ----------------------------------------------------------------------------
// CAN segment reassembler controller
// Sequences frame capture, the check/store cycle and word emission.
// ----------------------------------------------------------------------------
module csr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  csr_pkg::status_t status,
    output csr_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.emit ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (status.last_issue)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    // Commands to the datapath.
    assign cmd.capture = start && !busy_reg;
    assign cmd.check   = (state_reg == S_CHECK);
    assign cmd.issue   = (state_reg == S_EMIT);
    assign busy        = busy_reg;

endmodule

@@ hw/rtl/csr_datapath.sv @@
// ----------------------------------------------------------------------------
// CAN segment reassembler datapath
// Frame filter, per-source counts and headers, the eight-lane message store
// and the word emitter.
// ----------------------------------------------------------------------------
module csr_datapath #(
    parameter int BUF_BYTES = 256,
    parameter int SOURCES   = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csr_pkg::cmd_t        cmd,
    output csr_pkg::status_t     status,
    input  logic                 cfg_write_en,
    input  logic [4:0]           cfg_write_data,
    input  logic [4:0]           frame_target,
    input  logic [4:0]           frame_source,
    input  logic [2:0]           segment_kind,
    input  logic [3:0]           frame_length,
    input  logic [7:0][7:0]      frame_bytes,
    output logic                 result_valid,
    output logic                 destination,
    output logic [2:0]           message_source,
    output logic [8:0]           message_length,
    output logic [63:0]          word_data,
    output logic [3:0]           word_bytes,
    output logic                 last_word
);

    localparam int LANES  = csr_pkg::LANES;
    localparam int ROWS   = BUF_BYTES / LANES;
    localparam int SLOT_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CNT_W  = $clog2(BUF_BYTES + 1);
    localparam int TOT_W  = (CNT_W > 9) ? CNT_W : 9;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH  = SOURCES * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WW     = csr_pkg::WORDS_W;

    localparam logic [2:0] K_SINGLE = 3'd0;
    localparam logic [2:0] K_BEGIN  = 3'd1;
    localparam logic [2:0] K_MIDDLE = 3'd2;
    localparam logic [2:0] K_FINISH = 3'd3;

    localparam logic [7:0] HOST_H0  = 8'hAF;
    localparam logic [7:0] HOST_H1  = 8'hCB;
    localparam logic [7:0] LOCAL_H0 = 8'hF3;
    localparam logic [7:0] LOCAL_H1 = 8'h04;

    // Configuration and captured frame.
    logic [4:0]      own_id_reg;
    logic [4:0]      tgt_reg;
    logic [4:0]      src_reg;
    logic [2:0]      kind_reg;
    logic [3:0]      len_reg;
    logic [7:0][7:0] bytes_reg;

    // Per-source state.
    logic [CNT_W-1:0] cnt_reg  [SOURCES];
    logic [7:0]       hdr0_reg [SOURCES];
    logic [7:0]       hdr1_reg [SOURCES];

    // Check-cycle decode.
    logic [SLOT_W-1:0] slot;
    logic              frame_ok;
    logic [3:0]        len_sat;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W:0]    sum;
    logic              is_restart;
    logic              is_append;
    logic [CNT_W-1:0]  offset;
    logic [CNT_W-1:0]  new_cnt;
    logic              do_write;
    logic [7:0]        new_h0;
    logic [7:0]        new_h1;
    logic              host;
    logic              to_local;
    logic              emit;
    logic [ADDR_W-1:0] slot_base;
    logic [TOT_W-1:0]  tot_new;
    logic [TOT_W:0]    tot_round;
    logic [TOT_W:0]    words_full;
    logic [WW-1:0]     words_new;

    // Store write lanes.
    logic [2:0]        lane_idx   [LANES];
    logic [ROW_W-1:0]  lane_row   [LANES];
    logic              lane_we    [LANES];
    logic [ADDR_W-1:0] lane_waddr [LANES];
    logic [7:0]        lane_wdata [LANES];
    logic [7:0]        lane_rdata [LANES];

    // Emission state.
    logic [TOT_W-1:0]  tot_reg;
    logic [WW-1:0]     words_reg;
    logic [WW-2:0]     w_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              dest_reg;
    logic [2:0]        msrc_reg;
    logic              valid_reg;
    logic [3:0]        wbytes_reg;
    logic              last_reg;
    logic [TOT_W-1:0]  rem;
    logic [3:0]        n_bytes;
    logic [ADDR_W-1:0] rd_addr;

    // Board address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            own_id_reg <= cfg_write_data;
        end
    end

    // Frame capture on acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_reg   <= frame_target;
            src_reg   <= frame_source;
            kind_reg  <= segment_kind;
            len_reg   <= frame_length;
            bytes_reg <= frame_bytes;
        end
    end

    // Filter, buffer placement and header match for the captured frame.
    always_comb
    begin
        slot       = SLOT_W'(src_reg - 5'd1);
        frame_ok   = (tgt_reg == own_id_reg) && (src_reg != 5'd0)
                     && (src_reg <= 5'(SOURCES));
        len_sat    = (len_reg > 4'd8) ? 4'd8 : len_reg;
        cur_cnt    = cnt_reg[slot];
        sum        = {1'b0, cur_cnt} + (CNT_W + 1)'(len_sat);
        is_restart = kind_reg inside {K_SINGLE, K_BEGIN};
        is_append  = kind_reg inside {K_MIDDLE, K_FINISH};
        offset     = is_restart ? '0 : cur_cnt;
        new_cnt    = is_restart ? CNT_W'(len_sat) : sum[CNT_W-1:0];
        do_write   = frame_ok && (is_restart
                     || (is_append && (sum <= (CNT_W + 1)'(BUF_BYTES))));

        // The first two message bytes, after this frame is placed.
        if ((offset == '0) && (len_sat != 4'd0))
        begin
            new_h0 = bytes_reg[0];
        end
        else
        begin
            new_h0 = hdr0_reg[slot];
        end
        if ((offset == '0) && (len_sat >= 4'd2))
        begin
            new_h1 = bytes_reg[1];
        end
        else if ((offset == CNT_W'(1)) && (len_sat != 4'd0))
        begin
            new_h1 = bytes_reg[0];
        end
        else
        begin
            new_h1 = hdr1_reg[slot];
        end

        host     = (new_cnt >= CNT_W'(2)) && (new_h0 == HOST_H0) && (new_h1 == HOST_H1);
        to_local = (new_cnt >= CNT_W'(2)) && (new_h0 == LOCAL_H0) && (new_h1 == LOCAL_H1);
        emit     = do_write && (((kind_reg == K_SINGLE) && host)
                   || ((kind_reg == K_FINISH) && (host || to_local)));

        slot_base  = ADDR_W'(slot) * ADDR_W'(ROWS);
        tot_new    = TOT_W'(new_cnt);
        tot_round  = (TOT_W + 1)'(tot_new) + (TOT_W + 1)'(7);
        words_full = tot_round >> 3;
        words_new  = (words_full > (TOT_W + 1)'(csr_pkg::MAX_WORDS))
                     ? WW'(csr_pkg::MAX_WORDS) : words_full[WW-1:0];
    end

    // Lane steering: frame byte i lands in lane (offset + i) mod 8.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_idx[l]   = 3'(l) - offset[2:0];
            lane_row[l]   = ROW_W'(offset >> 3) + ROW_W'(3'(l) < offset[2:0]);
            lane_we[l]    = cmd.check && do_write && ({1'b0, lane_idx[l]} < len_sat);
            lane_waddr[l] = slot_base + ADDR_W'(lane_row[l]);
            lane_wdata[l] = bytes_reg[lane_idx[l]];
        end
    end

    // Per-source byte count and header bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SOURCES; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else if (cmd.check && do_write)
        begin
            cnt_reg[slot] <= (kind_reg == K_FINISH) ? '0 : new_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check && do_write)
        begin
            hdr0_reg[slot] <= new_h0;
            hdr1_reg[slot] <= new_h1;
        end
    end

    // Message store: one RAM per byte lane, one row holds one word.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        csr_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (lane_we[g]),
            .waddr (lane_waddr[g]),
            .wdata (lane_wdata[g]),
            .raddr (rd_addr),
            .rdata (lane_rdata[g])
        );
    end

    // Word emitter: bytes in the word being read and its read address.
    always_comb
    begin
        rem     = tot_reg - TOT_W'({w_reg, 3'b000});
        n_bytes = (rem > TOT_W'(8)) ? 4'd8 : rem[3:0];
        rd_addr = base_reg + ADDR_W'(w_reg);
    end

    assign status.emit       = emit;
    assign status.last_issue = (({1'b0, w_reg} + WW'(1)) == words_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.check && emit)
        begin
            tot_reg   <= tot_new;
            words_reg <= words_new;
            w_reg     <= '0;
            base_reg  <= slot_base;
            dest_reg  <= (kind_reg == K_FINISH) && !host;
            msrc_reg  <= src_reg[2:0];
        end
        else if (cmd.issue)
        begin
            w_reg <= w_reg + 1'b1;
        end
        if (cmd.issue)
        begin
            wbytes_reg <= n_bytes;
            last_reg   <= status.last_issue;
        end
    end

    // Result strobe lines up with the registered RAM read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.issue;
        end
    end

    // Result ports; bytes past the valid count read as zero.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            word_data[8*l +: 8] = (4'(l) < wbytes_reg) ? lane_rdata[l] : 8'h00;
        end
    end

    assign result_valid   = valid_reg;
    assign destination    = dest_reg;
    assign message_source = msrc_reg;
    assign message_length = tot_reg[8:0];
    assign word_bytes     = wbytes_reg;
    assign last_word      = last_reg;

endmodule

@@ hw/rtl/can_segment_reassembler_unit.sv @@
// ----------------------------------------------------------------------------
// CAN segment reassembler
// Collects multi-frame CAN messages per source board and emits completed
// messages as 64-bit words toward the host link or the local handler.
//
// Usage: drive a decoded frame on the frame ports and pulse start; the item
// is taken at a clock edge with start high and busy low. Frames for another
// board address or from a source outside 1..SOURCES are dropped. The board
// address is written through cfg_write_en / cfg_write_data; the user must do
// so only while idle, as the block itself does not enforce it. Each frame is
// registered at capture, then filtered and stored in the check/store state,
// where its bytes, up to eight, go into the eight byte-lane RAMs together.
// A completing frame then reads one word per cycle from the lane RAMs in the
// emit state, W words in all (W up to 32); the read data and result_valid are
// registered. Each word is shown for one cycle with result_valid high, and
// the receiver cannot stall it. busy stays high through both states.
// Reset clears the board address and all per-source byte counts; the
// message store itself needs no clearing.
// ----------------------------------------------------------------------------
module can_segment_reassembler_unit #(
    parameter int BUF_BYTES = 256,
    parameter int SOURCES   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [4:0]  cfg_write_data,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  frame_target,
    input  logic [4:0]  frame_source,
    input  logic [2:0]  segment_kind,
    input  logic [3:0]  frame_length,
    input  logic [7:0]  byte_0,
    input  logic [7:0]  byte_1,
    input  logic [7:0]  byte_2,
    input  logic [7:0]  byte_3,
    input  logic [7:0]  byte_4,
    input  logic [7:0]  byte_5,
    input  logic [7:0]  byte_6,
    input  logic [7:0]  byte_7,
    output logic        result_valid,
    output logic        destination,
    output logic [2:0]  message_source,
    output logic [8:0]  message_length,
    output logic [63:0] word_data,
    output logic [3:0]  word_bytes,
    output logic        last_word
);

    csr_pkg::cmd_t    cmd;
    csr_pkg::status_t status;
    logic [7:0][7:0]  frame_bytes;

    // Gather the frame bytes, byte 0 in the lowest lane.
    assign frame_bytes = {byte_7, byte_6, byte_5, byte_4,
                          byte_3, byte_2, byte_1, byte_0};

    // Sequencer.
    csr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Filter, store and emitter.
    csr_datapath #(
        .BUF_BYTES (BUF_BYTES),
        .SOURCES   (SOURCES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .frame_target   (frame_target),
        .frame_source   (frame_source),
        .segment_kind   (segment_kind),
        .frame_length   (frame_length),
        .frame_bytes    (frame_bytes),
        .result_valid   (result_valid),
        .destination    (destination),
        .message_source (message_source),
        .message_length (message_length),
        .word_data      (word_data),
        .word_bytes     (word_bytes),
        .last_word      (last_word)
    );

endmodule

@@ tb/sv/tb_can_segment_reassembler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CAN segment reassembler
// Feeds decoded CAN frames through the start/busy handshake and checks every
// emitted word against a per-source reassembly predictor kept in this file.
// A short table of directed frames runs first at the reset board address;
// then several phases of random message runs and noise follow, each under
// its own board address. The sender idles in random bursts, except in the
// last phase.
// ----------------------------------------------------------------------------
module tb_can_segment_reassembler_unit;

    localparam int BUF_BYTES = 256;
    localparam int SOURCES   = 4;
    localparam int LANES     = csr_pkg::LANES;
    localparam int MAX_WORDS = csr_pkg::MAX_WORDS;

    // Segment kinds; the last two are reserved values the block ignores.
    localparam bit [2:0] SEG_SINGLE  = 3'd0;
    localparam bit [2:0] SEG_BEGIN   = 3'd1;
    localparam bit [2:0] SEG_MIDDLE  = 3'd2;
    localparam bit [2:0] SEG_FINISH  = 3'd3;
    localparam bit [2:0] SEG_RSVD_LO = 3'd4;
    localparam bit [2:0] SEG_RSVD_HI = 3'd7;

    // Destinations and the two message headers, byte 0 in the low half.
    localparam bit        DEST_HOST    = 1'b0;
    localparam bit        DEST_LOCAL   = 1'b1;
    localparam bit [15:0] HOST_HEADER  = 16'hCBAF;
    localparam bit [15:0] LOCAL_HEADER = 16'h04F3;

    localparam int PREDICTED      = -1;
    localparam int PHASES         = 6;
    localparam int RANDOM_ITEMS   = 360;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        bit [4:0]  target;
        bit [4:0]  source;
        bit [2:0]  kind;
        bit [3:0]  length;
        bit [63:0] payload;
    } frame_t;

    typedef struct packed {
        bit        dest;
        bit [2:0]  src;
        bit [8:0]  len;
        bit [63:0] data;
        bit [3:0]  nbytes;
        bit        last;
    } word_t;

    typedef struct {
        frame_t frm;
        int     n_exp;
        word_t  w;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [4:0]  cfg_write_data;
    logic        start;
    logic        busy;
    logic [4:0]  frame_target;
    logic [4:0]  frame_source;
    logic [2:0]  segment_kind;
    logic [3:0]  frame_length;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
    logic        result_valid;
    logic        destination;
    logic [2:0]  message_source;
    logic [8:0]  message_length;
    logic [63:0] word_data;
    logic [3:0]  word_bytes;
    logic        last_word;

    // Predictor state: board address, per-source byte buffers and counts.
    bit [4:0]    board_id;
    bit [7:0]    msg_buf [SOURCES][BUF_BYTES];
    int unsigned msg_count [SOURCES];

    word_t pending_words[$];
    row_t  directed_rows[$];
    int    mismatches;
    int    useful_items;
    int    stall_cycles;
    bit    gaps_on;

    can_segment_reassembler_unit #(
        .BUF_BYTES(BUF_BYTES),
        .SOURCES  (SOURCES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .start         (start),
        .busy          (busy),
        .frame_target  (frame_target),
        .frame_source  (frame_source),
        .segment_kind  (segment_kind),
        .frame_length  (frame_length),
        .byte_0        (byte_0),
        .byte_1        (byte_1),
        .byte_2        (byte_2),
        .byte_3        (byte_3),
        .byte_4        (byte_4),
        .byte_5        (byte_5),
        .byte_6        (byte_6),
        .byte_7        (byte_7),
        .result_valid  (result_valid),
        .destination   (destination),
        .message_source(message_source),
        .message_length(message_length),
        .word_data     (word_data),
        .word_bytes    (word_bytes),
        .last_word     (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Split a completed message into 8-byte words and queue them.
    function automatic void queue_message_words(input int unsigned slot, input bit dest);
        int unsigned total;
        int unsigned words;
        int unsigned base;
        int unsigned n;
        int unsigned w;
        int unsigned k;
        word_t       wd;
        total = msg_count[slot];
        words = (total + LANES - 1) / LANES;
        if (words > MAX_WORDS)
            words = MAX_WORDS;
        for (w = 0; w < words; w++)
        begin
            base = w * LANES;
            n = total - base;
            if (n > LANES)
                n = LANES;
            wd.data = '0;
            for (k = 0; k < n; k++)
                wd.data[8*k +: 8] = msg_buf[slot][base + k];
            wd.dest   = dest;
            wd.src    = 3'(slot + 1);
            wd.len    = 9'(total);
            wd.nbytes = 4'(n);
            wd.last   = (w + 1 == words);
            pending_words.push_back(wd);
        end
    endfunction

    // Apply one frame to the per-source buffers. Returns 1 when the frame
    // is addressed here from a valid source with a known segment kind. Words
    // are queued only when want_words is set.
    function automatic bit reassemble_frame(input frame_t f, input bit want_words);
        int unsigned slot;
        int unsigned n;
        int unsigned cnt;
        int unsigned i;
        bit          host;
        bit          loc;
        if (f.target != board_id || f.source < 1 || f.source > SOURCES || f.kind > SEG_FINISH)
            return 1'b0;
        n = (f.length > LANES) ? LANES : f.length;
        slot = f.source - 1;
        cnt = msg_count[slot];
        // Single and begin restart the buffer; only a single can complete here.
        if (f.kind == SEG_SINGLE || f.kind == SEG_BEGIN)
        begin
            for (i = 0; i < n; i++)
                msg_buf[slot][i] = f.payload[8*i +: 8];
            msg_count[slot] = n;
            if (want_words && f.kind == SEG_SINGLE && n >= 2 &&
                msg_buf[slot][0] == HOST_HEADER[7:0] && msg_buf[slot][1] == HOST_HEADER[15:8])
                queue_message_words(slot, DEST_HOST);
            return 1'b1;
        end
        // An append that would overflow the buffer leaves everything as it is.
        if (cnt + n > BUF_BYTES)
            return 1'b1;
        for (i = 0; i < n; i++)
            msg_buf[slot][cnt + i] = f.payload[8*i +: 8];
        cnt += n;
        msg_count[slot] = cnt;
        if (f.kind == SEG_FINISH)
        begin
            host = cnt >= 2 && msg_buf[slot][0] == HOST_HEADER[7:0] &&
                   msg_buf[slot][1] == HOST_HEADER[15:8];
            loc  = cnt >= 2 && msg_buf[slot][0] == LOCAL_HEADER[7:0] &&
                   msg_buf[slot][1] == LOCAL_HEADER[15:8];
            if (want_words && host)
                queue_message_words(slot, DEST_HOST);
            else if (want_words && loc)
                queue_message_words(slot, DEST_LOCAL);
            msg_count[slot] = 0;
        end
        return 1'b1;
    endfunction

    function automatic frame_t make_frame(input bit [4:0] tgt, input bit [4:0] src,
                                          input bit [2:0] kind, input bit [3:0] len,
                                          input bit [63:0] payload);
        frame_t f;
        f.target  = tgt;
        f.source  = src;
        f.kind    = kind;
        f.length  = len;
        f.payload = payload;
        return f;
    endfunction

    function automatic word_t single_word(input bit dest, input bit [2:0] src,
                                          input bit [8:0] len, input bit [63:0] data,
                                          input bit [3:0] nbytes);
        word_t w;
        w.dest   = dest;
        w.src    = src;
        w.len    = len;
        w.data   = data;
        w.nbytes = nbytes;
        w.last   = 1'b1;
        return w;
    endfunction

    function automatic bit [3:0] rand_len();
        return ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    endfunction

    function automatic bit [63:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    task automatic add_row(input frame_t f, input int n_exp, input word_t w);
        row_t r;
        r.frm   = f;
        r.n_exp = n_exp;
        r.w     = w;
        directed_rows.push_back(r);
    endtask

    // Present one item, optionally after an idle burst, and wait until taken.
    task automatic send_frame(input frame_t f, input bit want_words);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        start        <= 1'b1;
        frame_target <= f.target;
        frame_source <= f.source;
        segment_kind <= f.kind;
        frame_length <= f.length;
        byte_0       <= f.payload[7:0];
        byte_1       <= f.payload[15:8];
        byte_2       <= f.payload[23:16];
        byte_3       <= f.payload[31:24];
        byte_4       <= f.payload[39:32];
        byte_5       <= f.payload[47:40];
        byte_6       <= f.payload[55:48];
        byte_7       <= f.payload[63:56];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (reassemble_frame(f, want_words))
            useful_items++;
    endtask

    // Change the board address once the block has drained.
    task automatic set_board_id(input bit [4:0] id);
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= id;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        board_id = id;
    endtask

    // One message from one source: a single, a begin/middle/finish run, or
    // occasionally a run long enough to fill and overflow the buffer.
    task automatic send_message_run();
        bit [4:0]  tgt;
        bit [4:0]  src;
        bit [15:0] hdr;
        bit [63:0] pl;
        bit        exact;
        int        middles;
        int        i;
        tgt = ($urandom_range(0, 19) == 0) ? 5'($urandom) : board_id;
        src = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, SOURCES));
        case ($urandom_range(0, 4))
            0, 1:    hdr = HOST_HEADER;
            2, 3:    hdr = LOCAL_HEADER;
            default: hdr = 16'($urandom);
        endcase
        pl = rand_payload();
        pl[15:0] = hdr;
        if ($urandom_range(0, 4) == 0)
        begin
            send_frame(make_frame(tgt, src, SEG_SINGLE, rand_len(), pl), 1'b1);
            return;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            // Exact runs land on a full buffer, then try one more middle.
            exact = 1'($urandom_range(0, 1));
            send_frame(make_frame(tgt, src, SEG_BEGIN, 4'd8, pl), 1'b1);
            for (i = 0; i < 32; i++)
                send_frame(make_frame(tgt, src, SEG_MIDDLE,
                                      exact ? 4'd8 : 4'($urandom_range(6, 15)),
                                      rand_payload()), 1'b1);
            send_frame(make_frame(tgt, src, SEG_FINISH, rand_len(), rand_payload()), 1'b1);
            send_frame(make_frame(tgt, src, SEG_FINISH, 4'd0, rand_payload()), 1'b1);
            return;
        end
        send_frame(make_frame(tgt, src, SEG_BEGIN, rand_len(), pl), 1'b1);
        middles = $urandom_range(0, 4);
        for (i = 0; i < middles; i++)
            send_frame(make_frame(tgt, src, SEG_MIDDLE, rand_len(), rand_payload()), 1'b1);
        send_frame(make_frame(tgt, src, SEG_FINISH, rand_len(), rand_payload()), 1'b1);
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        int        ph;
        int        goal;
        bit [4:0]  id;
        frame_t    f;
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        start          <= 1'b0;
        frame_target   <= '0;
        frame_source   <= '0;
        segment_kind   <= '0;
        frame_length   <= '0;
        byte_0         <= '0;
        byte_1         <= '0;
        byte_2         <= '0;
        byte_3         <= '0;
        byte_4         <= '0;
        byte_5         <= '0;
        byte_6         <= '0;
        byte_7         <= '0;
        board_id     = '0;
        mismatches   = 0;
        useful_items = 0;
        gaps_on      = 1'b1;

        // Directed frames, all at the reset board address 0.
        add_row(make_frame(5'd5, 5'd1, SEG_SINGLE, 4'd2, 64'hCBAF), 0, '0);
        add_row(make_frame(5'd0, 5'd0, SEG_SINGLE, 4'd2, 64'hCBAF), 0, '0);
        add_row(make_frame(5'd0, 5'd5, SEG_SINGLE, 4'd2, 64'hCBAF), 0, '0);
        add_row(make_frame(5'd0, 5'd31, SEG_FINISH, 4'd8, 64'hCBAF), 0, '0);
        add_row(make_frame(5'd0, 5'd1, SEG_SINGLE, 4'd2, 64'h5A5A_5A5A_5A5A_CBAF), 1,
                single_word(DEST_HOST, 3'd1, 9'd2, 64'hCBAF, 4'd2));
        add_row(make_frame(5'd0, 5'd2, SEG_RSVD_LO, 4'd2, 64'hCBAF), 0, '0);
        add_row(make_frame(5'd0, 5'd2, SEG_RSVD_HI, 4'd2, 64'hCBAF), 0, '0);
        // A one-byte message cannot match a header.
        add_row(make_frame(5'd0, 5'd3, SEG_SINGLE, 4'd1, 64'hAF), 0, '0);
        // Length 15 saturates to a full word.
        add_row(make_frame(5'd0, 5'd4, SEG_SINGLE, 4'd15, 64'hFFFF_FFFF_FFFF_CBAF), 1,
                single_word(DEST_HOST, 3'd4, 9'd8, 64'hFFFF_FFFF_FFFF_CBAF, 4'd8));
        add_row(make_frame(5'd0, 5'd1, SEG_SINGLE, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF), 0, '0);
        add_row(make_frame(5'd0, 5'd1, SEG_FINISH, 4'd0, 64'h0), 0, '0);
        // Four-frame local message of 19 bytes.
        add_row(make_frame(5'd0, 5'd2, SEG_BEGIN, 4'd8, 64'h0706_0504_0302_04F3), 0, '0);
        add_row(make_frame(5'd0, 5'd2, SEG_MIDDLE, 4'd8, 64'h1716_1514_1312_1110), 0, '0);
        add_row(make_frame(5'd0, 5'd2, SEG_MIDDLE, 4'd0, 64'h0), 0, '0);
        add_row(make_frame(5'd0, 5'd2, SEG_FINISH, 4'd3, 64'hFFFF_FFFF_FF22_2120),
                PREDICTED, '0);
        add_row(make_frame(5'd0, 5'd3, SEG_BEGIN, 4'd8, 64'h3736_3534_3332_CBAF), 0, '0);
        add_row(make_frame(5'd0, 5'd3, SEG_FINISH, 4'd9, 64'hFFEE_DDCC_BBAA_9988),
                PREDICTED, '0);
        // A single with the local header emits nothing; the finish does.
        add_row(make_frame(5'd0, 5'd4, SEG_SINGLE, 4'd8, 64'h4746_4544_4342_04F3), 0, '0);
        add_row(make_frame(5'd0, 5'd4, SEG_FINISH, 4'd1, 64'h00), PREDICTED, '0);
        // Finish without a header match still clears the count.
        add_row(make_frame(5'd0, 5'd1, SEG_BEGIN, 4'd2, 64'h3412), 0, '0);
        add_row(make_frame(5'd0, 5'd1, SEG_FINISH, 4'd0, 64'h0), 0, '0);
        add_row(make_frame(5'd0, 5'd1, SEG_FINISH, 4'd2, 64'h1111_1111_1111_CBAF), 1,
                single_word(DEST_HOST, 3'd1, 9'd2, 64'hCBAF, 4'd2));
        add_row(make_frame(5'd0, 5'd3, SEG_SINGLE, 4'd2, 64'h04F3), 0, '0);
        add_row(make_frame(5'd31, 5'd3, SEG_SINGLE, 4'd2, 64'hCBAF), 0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_frame(directed_rows[r].frm, directed_rows[r].n_exp == PREDICTED);
            if (directed_rows[r].n_exp == 1)
                pending_words.push_back(directed_rows[r].w);
        end

        // Random phases, each under its own board address.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       id = 5'd31;
                1:       id = 5'd0;
                2:       id = 5'd21;
                3:       id = 5'd10;
                default: id = 5'($urandom);
            endcase
            set_board_id(id);
            gaps_on = (ph != PHASES - 1);
            goal = useful_items + RANDOM_ITEMS / PHASES;
            while (useful_items < goal)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    // Noise: any field value, half of it addressed here.
                    f = make_frame($urandom_range(0, 1) ? board_id : 5'($urandom),
                                   5'($urandom_range(0, 7)), 3'($urandom), 4'($urandom),
                                   rand_payload());
                    send_frame(f, 1'b1);
                end
                else
                    send_message_run();
            end
        end

        // Drain and report.
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Compare each emitted word with the oldest expected one.
    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: dest %0d src %0d len %0d data %h bytes %0d last %0d",
                             destination, message_source, message_length, word_data,
                             word_bytes, last_word);
            end
            else
            begin
                want = pending_words.pop_front();
                if (destination !== want.dest || message_source !== want.src ||
                    message_length !== want.len || word_data !== want.data ||
                    word_bytes !== want.nbytes || last_word !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("word mismatch: expected dest %0d src %0d len %0d data %h bytes %0d last %0d",
                                 want.dest, want.src, want.len, want.data, want.nbytes, want.last);
                        $display("               actual   dest %0d src %0d len %0d data %h bytes %0d last %0d",
                                 destination, message_source, message_length, word_data,
                                 word_bytes, last_word);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
